// ----- rtl/plns_pkg.sv -----
// shared types and constants for the priority level nesting stack
`default_nettype none

package plns_pkg;

    localparam int LEVEL_W  = 4;
    localparam int REQ_W    = 8;
    localparam int EXEC_W   = 8;
    localparam int STATUS_W = 3;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam level_t HIGHEST_LEVEL  = 4'd15;
    localparam level_t DISPATCH_LEVEL = 4'd2;

    // result status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_NO_EXEC   = 3'd1;
    localparam status_t ST_BAD_RAISE = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_MISMATCH  = 3'd4;
    localparam status_t ST_CANCEL    = 3'd5;
    localparam status_t ST_SPINLOCK  = 3'd6;
    localparam status_t ST_INTLOCK   = 3'd7;

    // request codes
    localparam logic FN_RAISE = 1'b0;
    localparam logic FN_LOWER = 1'b1;

    // stack update chosen by the check logic
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    // what the check logic sees of the stack
    typedef struct packed {
        logic   empty;
        logic   full;
        level_t top_old;
        level_t top_new;
    } stack_view_t;

endpackage

`default_nettype wire

// ----- rtl/plns_ctrl.sv -----
// request checks: decides status, new level and stack update for one beat
`default_nettype none

module plns_ctrl #(
    parameter int EID_W = 8
) (
    input  wire logic                 req_valid,
    input  wire logic                 func,
    input  wire logic [7:0]           requested_level,
    input  wire logic [EID_W-1:0]     exec_id,
    input  wire logic                 cancel_lock_held,
    input  wire logic                 exec_spinlock_held,
    input  wire logic                 interrupt_hold_valid,
    input  wire logic [3:0]           interrupt_hold_level,
    input  wire plns_pkg::level_t     cur_level,
    input  wire plns_pkg::stack_view_t view,
    input  wire logic [EID_W-1:0]     top_exec,
    output plns_pkg::status_t         status,
    output plns_pkg::level_t          prev_level,
    output plns_pkg::level_t          next_level,
    output plns_pkg::stack_op_t       op
);
    import plns_pkg::*;

    logic in_range;
    logic below_dispatch;
    logic below_hold;
    logic top_match;

    // level compares on the full request byte
    assign in_range       = requested_level <= {4'b0, HIGHEST_LEVEL};
    assign below_dispatch = requested_level < {4'b0, DISPATCH_LEVEL};
    assign below_hold     = requested_level < {4'b0, interrupt_hold_level};
    assign top_match      = !view.empty && (top_exec == exec_id) &&
                            (view.top_new == cur_level) &&
                            ({4'b0, view.top_old} == requested_level);

    // check chain in priority order
    always_comb
    begin
        status     = ST_OK;
        prev_level = '0;
        next_level = cur_level;
        op         = '0;
        if (exec_id == '0)
        begin
            status = ST_NO_EXEC;
        end
        else if (func == FN_RAISE)
        begin
            if (!in_range || (requested_level[3:0] < cur_level))
                status = ST_BAD_RAISE;
            else if (view.full)
                status = ST_FULL;
            else
            begin
                op.push    = req_valid;
                prev_level = cur_level;
                next_level = requested_level[3:0];
            end
        end
        else
        begin
            if (!top_match)
                status = ST_MISMATCH;
            else if (below_dispatch && cancel_lock_held)
                status = ST_CANCEL;
            else if (below_dispatch && exec_spinlock_held)
                status = ST_SPINLOCK;
            else if (interrupt_hold_valid && below_hold)
                status = ST_INTLOCK;
            else
            begin
                op.pop     = req_valid;
                next_level = requested_level[3:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/plns_stack.sv -----
// level register, stack count, top entry in flops and the stack memory behind it
`default_nettype none

module plns_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int EID_W       = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire plns_pkg::stack_op_t   op,
    input  wire plns_pkg::level_t      next_level,
    input  wire logic [EID_W-1:0]      push_exec,
    output plns_pkg::level_t           cur_level,
    output plns_pkg::stack_view_t      view,
    output logic [EID_W-1:0]           top_exec
);
    import plns_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENT_W = EID_W + 2 * LEVEL_W;

    // entry layout: exec, old level, new level
    logic [ENT_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    level_t           level_reg, level_next;
    logic             refill_reg, refill_next;
    logic [ENT_W-1:0] top_reg, top_next;
    logic [ENT_W-1:0] rd_data_reg;
    logic [ENT_W-1:0] eff_top;
    logic [ENT_W-1:0] push_entry;
    logic [CNT_W-1:0] wr_cnt;
    logic [CNT_W-1:0] rd_cnt;

    // top comes from the read port in the cycle after a pop
    assign eff_top    = refill_reg ? rd_data_reg : top_reg;
    assign push_entry = {push_exec, level_reg, next_level};
    assign wr_cnt     = count_reg - CNT_W'(1);
    assign rd_cnt     = count_reg - CNT_W'(2);

    assign cur_level    = level_reg;
    assign top_exec     = eff_top[ENT_W-1 -: EID_W];
    assign view.top_old = eff_top[2*LEVEL_W-1 -: LEVEL_W];
    assign view.top_new = eff_top[LEVEL_W-1:0];
    assign view.empty   = count_reg == '0;
    assign view.full    = count_reg == CNT_W'(STACK_DEPTH);

    // next state
    always_comb
    begin
        count_next  = count_reg;
        level_next  = level_reg;
        top_next    = eff_top;
        refill_next = 1'b0;
        if (op.push)
        begin
            count_next = count_reg + CNT_W'(1);
            level_next = next_level;
            top_next   = push_entry;
        end
        else if (op.pop)
        begin
            count_next  = count_reg - CNT_W'(1);
            level_next  = next_level;
            refill_next = count_reg >= CNT_W'(2);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            level_reg  <= '0;
            refill_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            level_reg  <= level_next;
            refill_reg <= refill_next;
        end
    end

    // top entry payload
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // old top spills on push, entry below top is read on pop
    always_ff @(posedge clk)
    begin
        if (op.push && !view.empty)
            mem[wr_cnt[IDX_W-1:0]] <= eff_top;
        if (refill_next)
            rd_data_reg <= mem[rd_cnt[IDX_W-1:0]];
    end

endmodule

`default_nettype wire

// ----- rtl/priority_level_nesting_stack.sv -----
// top level: request register, check logic, stack and result register
//
// Priority level nesting stack. A request is taken on every clock edge where
// start is high; busy is never raised, so one request per cycle is sustained.
// The request register feeds the checks, whose outcome lands in the result
// register at the next edge: the result is shown for exactly one cycle with
// done high, starting one cycle after the accepting edge, and it must be
// captured at the second edge after acceptance. The top stack entry sits in
// flip-flops and the rest in a memory; after a lower the new top arrives
// from the memory's registered read port the next cycle and is forwarded,
// so back-to-back lowers run at full rate. Stack entries are only read after
// being written, so the memory needs no clearing after reset and requests
// are taken right away.
`default_nettype none

module priority_level_nesting_stack #(
    parameter int STACK_DEPTH  = 64,
    parameter int EXEC_ID_BITS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       func,
    input  wire logic [7:0] requested_level,
    input  wire logic [7:0] execution_id,
    input  wire logic       cancel_lock_held,
    input  wire logic       exec_spinlock_held,
    input  wire logic       interrupt_hold_valid,
    input  wire logic [3:0] interrupt_hold_level,
    output logic            done,
    output logic [2:0]      status,
    output logic [3:0]      previous_level,
    output logic [3:0]      level_now
);
    import plns_pkg::*;

    localparam int EID_W = (EXEC_ID_BITS < EXEC_W) ? EXEC_ID_BITS : EXEC_W;

    logic             req_valid_reg;
    logic             func_reg;
    logic [7:0]       req_level_reg;
    logic [EID_W-1:0] exec_reg;
    logic             cancel_reg;
    logic             spin_reg;
    logic             hold_valid_reg;
    logic [3:0]       hold_level_reg;

    logic             done_reg;
    status_t          status_reg;
    level_t           prev_reg;
    level_t           level_now_reg;

    status_t          chk_status;
    level_t           chk_prev;
    level_t           chk_next_level;
    stack_op_t        stk_op;
    stack_view_t      stk_view;
    level_t           cur_level;
    logic [EID_W-1:0] top_exec;

    // every cycle can take a beat
    assign busy = 1'b0;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg       <= func;
            req_level_reg  <= requested_level;
            exec_reg       <= execution_id[EID_W-1:0];
            cancel_reg     <= cancel_lock_held;
            spin_reg       <= exec_spinlock_held;
            hold_valid_reg <= interrupt_hold_valid;
            hold_level_reg <= interrupt_hold_level;
        end
    end

    plns_ctrl #(
        .EID_W (EID_W)
    ) u_ctrl (
        .req_valid            (req_valid_reg),
        .func                 (func_reg),
        .requested_level      (req_level_reg),
        .exec_id              (exec_reg),
        .cancel_lock_held     (cancel_reg),
        .exec_spinlock_held   (spin_reg),
        .interrupt_hold_valid (hold_valid_reg),
        .interrupt_hold_level (hold_level_reg),
        .cur_level            (cur_level),
        .view                 (stk_view),
        .top_exec             (top_exec),
        .status               (chk_status),
        .prev_level           (chk_prev),
        .next_level           (chk_next_level),
        .op                   (stk_op)
    );

    plns_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .EID_W       (EID_W)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (stk_op),
        .next_level (chk_next_level),
        .push_exec  (exec_reg),
        .cur_level  (cur_level),
        .view       (stk_view),
        .top_exec   (top_exec)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            status_reg    <= chk_status;
            prev_reg      <= chk_prev;
            level_now_reg <= chk_next_level;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign previous_level = prev_reg;
    assign level_now      = level_now_reg;

`ifndef SYNTHESIS
    // every accepted beat yields a result through the request and result registers
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing after accepted beat");

    // refused requests report no previous level
    a_refused_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (previous_level == 4'd0))
        else $error("previous level set on refused request");

    // a push never happens on a full stack
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stk_op.push |-> !stk_view.full)
        else $error("push on full stack");

    // a pop never happens on an empty stack
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        stk_op.pop |-> !stk_view.empty)
        else $error("pop on empty stack");
`endif

endmodule

`default_nettype wire

// ----- bench/plns_level_checker.sv -----
// checker for the priority level nesting stack: level prediction and result compare
`default_nettype none

module plns_level_checker #(
    parameter int STACK_DEPTH  = 64,
    parameter int EXEC_ID_BITS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       func,
    input  wire logic [7:0] requested_level,
    input  wire logic [7:0] execution_id,
    input  wire logic       cancel_lock_held,
    input  wire logic       exec_spinlock_held,
    input  wire logic       interrupt_hold_valid,
    input  wire logic [3:0] interrupt_hold_level,
    input  wire logic       done,
    input  wire logic [2:0] status,
    input  wire logic [3:0] previous_level,
    input  wire logic [3:0] level_now,
    output int              fail_count,
    output int              pending,
    output plns_pkg::level_t level_pred,
    output int              depth_pred,
    output logic [7:0]      top_exec,
    output plns_pkg::level_t top_old
);
    import plns_pkg::*;

    typedef struct packed {
        status_t code;
        level_t  prior;
        level_t  after;
    } level_result_t;

    // predicted block state
    level_t     cur_level;
    int         saved_depth;
    logic [7:0] saved_exec  [STACK_DEPTH];
    level_t     saved_old   [STACK_DEPTH];
    level_t     saved_new   [STACK_DEPTH];

    // results still owed by the block, oldest first
    level_result_t owed_results[$];

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // apply one request to the predicted stack and return its result
    task automatic serve_level_request(
        input  logic          fn,
        input  logic [7:0]    req,
        input  logic [7:0]    id,
        input  logic          cancel_held,
        input  logic          spin_held,
        input  logic          hold_valid,
        input  level_t        hold_level,
        output level_result_t res
    );
        logic [7:0] who;
        int         top;
        who = id & 8'((64'd1 << EXEC_ID_BITS) - 64'd1);
        res.code  = ST_OK;
        res.prior = '0;
        if (who == 8'd0) begin
            res.code = ST_NO_EXEC;
        end
        else if (fn == FN_RAISE) begin
            if (req > HIGHEST_LEVEL || req < cur_level) begin
                res.code = ST_BAD_RAISE;
            end
            else if (saved_depth >= STACK_DEPTH) begin
                res.code = ST_FULL;
            end
            else begin
                saved_exec[saved_depth] = who;
                saved_old[saved_depth]  = cur_level;
                saved_new[saved_depth]  = req[3:0];
                saved_depth++;
                res.prior = cur_level;
                cur_level = req[3:0];
            end
        end
        else begin
            top = saved_depth - 1;
            if (saved_depth == 0) begin
                res.code = ST_MISMATCH;
            end
            else if (saved_exec[top] != who || saved_new[top] != cur_level ||
                     {4'd0, saved_old[top]} != req) begin
                res.code = ST_MISMATCH;
            end
            else if (req < DISPATCH_LEVEL && cancel_held) begin
                res.code = ST_CANCEL;
            end
            else if (req < DISPATCH_LEVEL && spin_held) begin
                res.code = ST_SPINLOCK;
            end
            else if (hold_valid && req < hold_level) begin
                res.code = ST_INTLOCK;
            end
            else begin
                saved_depth = top;
                cur_level   = req[3:0];
            end
        end
        res.after = cur_level;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        level_result_t want;
        level_result_t got;
        if (!rst_n)
        begin
            cur_level   = '0;
            saved_depth = 0;
            owed_results.delete();
        end
        else
        begin
            // result beat against the oldest owed result
            if (done !== 1'b0)
            begin
                if (done !== 1'b1)
                begin
                    report("done is unknown");
                end
                else if (owed_results.size() == 0)
                begin
                    report("result beat with no request waiting");
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (status !== want.code)
                        report($sformatf("status field got %0d want %0d", status, want.code));
                    if (previous_level !== want.prior)
                        report($sformatf("previous_level got %0d want %0d",
                                         previous_level, want.prior));
                    if (level_now !== want.after)
                        report($sformatf("level_now got %0d want %0d", level_now, want.after));
                end
            end
            // accepted request beat
            if (start === 1'b1 && busy === 1'b0)
            begin
                serve_level_request(func, requested_level, execution_id, cancel_lock_held,
                                    exec_spinlock_held, interrupt_hold_valid,
                                    interrupt_hold_level, got);
                owed_results = {owed_results, got};
            end
        end
        // predicted state for the stimulus side
        pending    = owed_results.size();
        level_pred = cur_level;
        depth_pred = saved_depth;
        top_exec   = (saved_depth > 0) ? saved_exec[saved_depth-1] : 8'd0;
        top_old    = (saved_depth > 0) ? saved_old[saved_depth-1] : level_t'(0);
    end

endmodule

`default_nettype wire

// ----- bench/tb_priority_level_nesting_stack.sv -----
// testbench top for the priority level nesting stack: stimulus and verdict
`default_nettype none

module tb_priority_level_nesting_stack;
    import plns_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int EXEC_ID_BITS = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 170;

    typedef struct packed {
        logic       fn;
        logic [7:0] req;
        logic [7:0] id;
        logic       cancel;
        logic       spin;
        logic       hold_v;
        level_t     hold_lvl;
    } level_request_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       func;
    logic [7:0] requested_level;
    logic [7:0] execution_id;
    logic       cancel_lock_held;
    logic       exec_spinlock_held;
    logic       interrupt_hold_valid;
    logic [3:0] interrupt_hold_level;
    logic       done;
    logic [2:0] status;
    logic [3:0] previous_level;
    logic [3:0] level_now;

    int         fail_count;
    int         pending;
    level_t     level_pred;
    int         depth_pred;
    logic [7:0] top_exec;
    level_t     top_old;

    int         sender_idle;
    int         cycle_count;

    priority_level_nesting_stack #(
        .STACK_DEPTH  (STACK_DEPTH),
        .EXEC_ID_BITS (EXEC_ID_BITS)
    ) DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .func                 (func),
        .requested_level      (requested_level),
        .execution_id         (execution_id),
        .cancel_lock_held     (cancel_lock_held),
        .exec_spinlock_held   (exec_spinlock_held),
        .interrupt_hold_valid (interrupt_hold_valid),
        .interrupt_hold_level (interrupt_hold_level),
        .done                 (done),
        .status               (status),
        .previous_level       (previous_level),
        .level_now            (level_now)
    );

    plns_level_checker #(
        .STACK_DEPTH  (STACK_DEPTH),
        .EXEC_ID_BITS (EXEC_ID_BITS)
    ) level_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .func                 (func),
        .requested_level      (requested_level),
        .execution_id         (execution_id),
        .cancel_lock_held     (cancel_lock_held),
        .exec_spinlock_held   (exec_spinlock_held),
        .interrupt_hold_valid (interrupt_hold_valid),
        .interrupt_hold_level (interrupt_hold_level),
        .done                 (done),
        .status               (status),
        .previous_level       (previous_level),
        .level_now            (level_now),
        .fail_count           (fail_count),
        .pending              (pending),
        .level_pred           (level_pred),
        .depth_pred           (depth_pred),
        .top_exec             (top_exec),
        .top_old              (top_old)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // drive one request beat after random sender gaps, called at a falling edge
    task automatic issue_item(input level_request_t rq);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start                <= 1'b1;
        func                 <= rq.fn;
        requested_level      <= rq.req;
        execution_id         <= rq.id;
        cancel_lock_held     <= rq.cancel;
        exec_spinlock_held   <= rq.spin;
        interrupt_hold_valid <= rq.hold_v;
        interrupt_hold_level <= rq.hold_lvl;
        do @(posedge clk); while (busy !== 1'b0);
        @(negedge clk);
    endtask

    initial
    begin
        level_request_t rq;
        int             roll;
        int             push_pct;
        cycle_count          = 0;
        sender_idle          = 0;
        rst_n                = 1'b0;
        start                = 1'b0;
        func                 = FN_RAISE;
        requested_level      = 8'd0;
        execution_id         = 8'd0;
        cancel_lock_held     = 1'b0;
        exec_spinlock_held   = 1'b0;
        interrupt_hold_valid = 1'b0;
        interrupt_hold_level = 4'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no execution, bad targets, equal raise, empty lower
        issue_item('{FN_RAISE, 8'd0,   8'h00, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd0,   8'h00, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd0,   8'h01, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd16,  8'h01, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd255, 8'h01, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd0,   8'h01, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd5,   8'hFF, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd3,   8'h02, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd5,   8'h80, 1'b0, 1'b0, 1'b0, 4'd0});
        // directed: lower mismatches and lock refusals in check order
        issue_item('{FN_LOWER, 8'd5,   8'h81, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd200, 8'h80, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd5,   8'h80, 1'b0, 1'b0, 1'b1, 4'd6});
        issue_item('{FN_LOWER, 8'd5,   8'h80, 1'b1, 1'b1, 1'b1, 4'd5});
        issue_item('{FN_LOWER, 8'd0,   8'hFF, 1'b1, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd0,   8'hFF, 1'b1, 1'b1, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd0,   8'hFF, 1'b0, 1'b1, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd0,   8'hFF, 1'b0, 1'b0, 1'b1, 4'd1});
        issue_item('{FN_LOWER, 8'd0,   8'hFF, 1'b0, 1'b0, 1'b1, 4'd0});
        // directed: top level, equal raise there, unwind to empty
        issue_item('{FN_RAISE, 8'd15,  8'h2A, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd15,  8'h55, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_RAISE, 8'd14,  8'h55, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd15,  8'h55, 1'b1, 1'b1, 1'b1, 4'd15});
        issue_item('{FN_LOWER, 8'd0,   8'h2A, 1'b0, 1'b0, 1'b0, 4'd0});
        issue_item('{FN_LOWER, 8'd0,   8'h01, 1'b0, 1'b0, 1'b1, 4'd0});

        // random: three sender idling phases, push bias changes every 60 beats
        push_pct = 55;
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle = (ph == 0) ? 33 : (ph == 1) ? 61 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 60 == 0)
                begin
                    roll     = $urandom_range(0, 2);
                    push_pct = (roll == 0) ? 20 : (roll == 1) ? 55 : 95;
                end
                rq.cancel   = ($urandom_range(0, 99) < 15);
                rq.spin     = ($urandom_range(0, 99) < 15);
                rq.hold_v   = ($urandom_range(0, 99) < 20);
                rq.hold_lvl = level_t'($urandom_range(0, 15));
                roll        = $urandom_range(0, 99);
                if (roll < 12)
                begin
                    // noise
                    rq.fn  = 1'($urandom);
                    rq.req = 8'($urandom);
                    rq.id  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
                end
                else if (roll < 18)
                begin
                    // broken sequences: wrong owner, wrong target, raise at or below
                    rq.id = top_exec;
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            rq.fn  = FN_LOWER;
                            rq.req = {4'd0, top_old};
                            rq.id  = top_exec ^ 8'($urandom_range(1, 255));
                        end
                        1:
                        begin
                            rq.fn  = FN_LOWER;
                            rq.req = 8'($urandom_range(0, 15));
                        end
                        default:
                        begin
                            rq.fn  = FN_RAISE;
                            rq.req = 8'($urandom_range(0, level_pred));
                            rq.id  = 8'($urandom_range(1, 255));
                        end
                    endcase
                end
                else if (depth_pred == STACK_DEPTH ? ($urandom_range(0, 3) != 0)
                         : (depth_pred > 0 && $urandom_range(0, 99) >= push_pct))
                begin
                    // well-formed lower of the top entry
                    rq.fn  = FN_LOWER;
                    rq.req = {4'd0, top_old};
                    rq.id  = top_exec;
                end
                else
                begin
                    // well-formed raise, often to the same level to build depth
                    rq.fn  = FN_RAISE;
                    rq.req = ($urandom_range(0, 1) == 0) ? {4'd0, level_pred}
                             : 8'($urandom_range(level_pred, 15));
                    rq.id  = 8'($urandom_range(1, 255));
                end
                issue_item(rq);
            end
        end
        start <= 1'b0;

        // drain the owed results, then watch for stray beats
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
